/* sv/uddp_pkg.sv */
// ----------------------------------------------------------------------------
// uddp_pkg
// Shared types and codes of the usage-dependent drop policer.
// ----------------------------------------------------------------------------
package uddp_pkg;

    localparam int NUM_REGS = 7;
    localparam int ETH_HDR  = 14;
    localparam logic [29:0] NS_PER_S = 30'd1000000000;

    localparam logic [1:0] VERDICT_PASS = 2'd0;
    localparam logic [1:0] VERDICT_DROP = 2'd1;
    localparam logic [1:0] VERDICT_TICK = 2'd2;

    // register indexes
    localparam logic [2:0] REG_INTERVAL = 3'd0;
    localparam logic [2:0] REG_LIMIT_0  = 3'd1;
    localparam logic [2:0] REG_LIMIT_1  = 3'd2;
    localparam logic [2:0] REG_LIMIT_2  = 3'd3;
    localparam logic [2:0] REG_LEVEL_0  = 3'd4;
    localparam logic [2:0] REG_LEVEL_1  = 3'd5;
    localparam logic [2:0] REG_LEVEL_2  = 3'd6;

    typedef enum logic [1:0] {
        K_V4,
        K_V6,
        K_OTHER,
        K_TICK
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [16:0]  len;
        logic [63:0]  now;
        logic [31:0]  rnd;
    } t_item;

    typedef struct packed {
        logic [11:0]      interval;
        logic [2:0][31:0] limit;
        logic [2:0][31:0] level;
    } t_cfg;

    typedef struct packed {
        logic [16:0] len;
        logic [63:0] tstamp;
    } t_ring;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_DEC,
        S_T_INIT,
        S_RD,
        S_CHK,
        S_DIV,
        S_T_OUT
    } t_state;

endpackage

/* sv/uddp_front.sv */
// ----------------------------------------------------------------------------
// uddp_front
// Accepts items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module uddp_front import uddp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [1:0]  i_family,
    input  logic [63:0] i_addr_low,
    input  logic [63:0] i_addr_high,
    input  logic [15:0] i_frame_length,
    input  logic [63:0] i_time_ns,
    input  logic [31:0] i_random_word,
    output logic        o_q_valid,
    output t_item       o_q_item,
    input  logic        i_q_pop
);

    t_item       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_item       w_item;
    logic        w_push;

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    always_comb begin
        w_item.now = i_time_ns;
        w_item.rnd = i_random_word;
        w_item.len = {1'b0, i_frame_length} + 17'(ETH_HDR);
        w_item.lo  = i_addr_low;
        w_item.hi  = 64'd0;
        if (i_req_type) begin
            w_item.kind = K_TICK;
        end else if (i_family == 2'd0) begin
            w_item.kind = K_V4;
            w_item.lo   = {32'd0, i_addr_low[31:0]};
        end else if (i_family == 2'd1) begin
            w_item.kind = K_V6;
            w_item.hi   = i_addr_high;
        end else begin
            w_item.kind = K_OTHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

endmodule

/* sv/uddp_back.sv */
// ----------------------------------------------------------------------------
// uddp_back
// Flow slot lookup, drop decision, ring logging and tick rate recompute.
// ----------------------------------------------------------------------------
module uddp_back import uddp_pkg::*; #(
    parameter int FLOWS_PER_FAMILY = 5,
    parameter int RING_DEPTH       = 1024,
    parameter int NUM_CLASSES      = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_verdict,
    output logic [1:0]  o_class_index,
    output logic [31:0] o_flow_rate
);

    localparam int NSLOTS = 2 * FLOWS_PER_FAMILY;
    localparam int SW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int FSW    = (FLOWS_PER_FAMILY > 1) ? $clog2(FLOWS_PER_FAMILY) : 1;
    localparam int RIW    = $clog2(RING_DEPTH);
    localparam int FW     = $clog2(RING_DEPTH + 1);
    localparam int AW     = $clog2(NSLOTS * RING_DEPTH);

    t_state r_state, n_state;
    t_item  r_item;

    logic [63:0]     r_slot_lo [NSLOTS];
    logic [63:0]     r_slot_hi [FLOWS_PER_FAMILY];
    logic [31:0]     r_slot_rate [NSLOTS];
    logic [RIW-1:0]  r_head [NSLOTS];
    logic [FW-1:0]   r_fill [NSLOTS];

    t_ring           r_mem [NSLOTS * RING_DEPTH];
    t_ring           r_rd;

    logic            r_claim;
    logic [SW-1:0]   r_cslot;
    logic [31:0]     r_rate;
    logic [41:0]     r_window;

    logic [SW-1:0]   r_slot;
    logic [RIW-1:0]  r_idx;
    logic [FW-1:0]   r_k, r_cnt;
    logic [31:0]     r_sum;
    logic [31:0]     r_dq;
    logic [11:0]     r_rem;
    logic [4:0]      r_dcnt;

    logic            r_out_valid;
    logic [1:0]      r_verdict, r_cls;
    logic [31:0]     r_out_rate;

    logic            l_hit, l_claim;
    logic [SW-1:0]   l_cslot;
    logic [31:0]     l_rate;
    logic [1:0]      w_cls;
    logic            w_drop;
    logic            w_out_free;
    logic [11:0]     w_eff;
    logic            w_stop;
    logic [31:0]     w_sum;
    logic [12:0]     w_dtmp;
    logic            w_dbit;
    logic [RIW-1:0]  w_prev_head;
    logic            w_v6;

    assign w_out_free  = !r_out_valid || i_ready;
    assign w_eff       = (i_cfg.interval == 12'd0) ? 12'd1 : i_cfg.interval;
    assign w_v6        = (r_item.kind == K_V6);
    assign w_prev_head = (r_head[r_slot] == '0) ? RIW'(RING_DEPTH - 1) : r_head[r_slot] - 1'b1;

    // destination lookup over the slots of the item's family
    always_comb begin
        logic          m, e;
        logic [SW-1:0] sel;
        l_hit   = 1'b0;
        l_claim = 1'b0;
        l_rate  = 32'd0;
        l_cslot = '0;
        for (int j = 0; j < FLOWS_PER_FAMILY; j++) begin
            if (w_v6) begin
                sel = SW'(FLOWS_PER_FAMILY + j);
                m = (r_slot_lo[FLOWS_PER_FAMILY + j] == r_item.lo) && (r_slot_hi[j] == r_item.hi);
                e = (r_slot_lo[FLOWS_PER_FAMILY + j] == 64'd0) && (r_slot_hi[j] == 64'd0);
            end else begin
                sel = SW'(j);
                m = (r_slot_lo[j] == r_item.lo);
                e = (r_slot_lo[j] == 64'd0);
            end
            if (m && !l_hit) begin
                l_hit  = 1'b1;
                l_rate = r_slot_rate[sel];
            end
            if ((m || e) && !l_claim) begin
                l_claim = 1'b1;
                l_cslot = sel;
            end
        end
    end

    // first class whose limit exceeds the rate, else the last one
    always_comb begin
        w_cls = 2'(NUM_CLASSES - 1);
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (r_rate < i_cfg.limit[c]) begin
                w_cls = 2'(c);
            end
        end
        w_drop = (i_cfg.level[w_cls] != 32'd0) && (i_cfg.level[w_cls] >= r_item.rnd);
    end

    // ring entry check, saturating accumulate and divider step
    always_comb begin
        logic [32:0] tmp;
        tmp    = {1'b0, r_sum} + {16'd0, r_rd.len};
        w_sum  = tmp[32] ? 32'hFFFF_FFFF : tmp[31:0];
        w_stop = (r_rd.tstamp > r_item.now) ||
                 ((r_item.now - r_rd.tstamp) > {22'd0, r_window});
        w_dtmp = {r_rem, r_dq[31]};
        w_dbit = (w_dtmp >= {1'b0, w_eff});
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && w_out_free) begin
                    n_state = (i_q_item.kind == K_TICK) ? S_T_INIT : S_LOOK;
                end
            end
            S_LOOK:   n_state = S_DEC;
            S_DEC:    n_state = S_IDLE;
            S_T_INIT: n_state = (r_fill[r_slot] == '0) ? S_DIV : S_RD;
            S_RD:     n_state = S_CHK;
            S_CHK: begin
                if (w_stop || (r_k + 1'b1 == r_cnt)) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_RD;
                end
            end
            S_DIV: begin
                if (r_dcnt == 5'd31) begin
                    n_state = (r_slot == SW'(NSLOTS - 1)) ? S_T_OUT : S_T_INIT;
                end
            end
            S_T_OUT:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = (r_state == S_IDLE) && i_q_valid && w_out_free;
    end

    // ring memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_DEC && r_item.kind != K_OTHER && !w_drop && r_claim) begin
            r_mem[AW'(r_cslot) * AW'(RING_DEPTH) + AW'(r_head[r_cslot])] <=
                '{len: r_item.len, tstamp: r_item.now};
        end
        if (r_state == S_RD) begin
            r_rd <= r_mem[AW'(r_slot) * AW'(RING_DEPTH) + AW'(r_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        r_window <= 42'(w_eff) * 42'(NS_PER_S);
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        case (r_state)
            S_LOOK: begin
                r_claim <= l_claim && (r_item.kind != K_OTHER);
                r_cslot <= l_cslot;
                r_rate  <= (r_item.kind == K_OTHER) ? 32'd0 : l_rate;
            end
            S_T_INIT: begin
                r_sum <= 32'd0;
                r_k   <= '0;
                r_cnt <= r_fill[r_slot];
                r_idx <= w_prev_head;
                r_dq  <= 32'd0;
                r_rem <= 12'd0;
                r_dcnt <= 5'd0;
            end
            S_CHK: begin
                if (!w_stop) begin
                    r_sum <= w_sum;
                    r_dq  <= w_sum;
                end else begin
                    r_dq  <= r_sum;
                end
                r_k   <= r_k + 1'b1;
                r_idx <= (r_idx == '0) ? RIW'(RING_DEPTH - 1) : r_idx - 1'b1;
            end
            S_DIV: begin
                r_rem  <= w_dbit ? 12'(w_dtmp - {1'b0, w_eff}) : w_dtmp[11:0];
                r_dq   <= {r_dq[30:0], w_dbit};
                r_dcnt <= r_dcnt + 5'd1;
            end
            default: ;
        endcase

        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_slot      <= '0;
            for (int s = 0; s < NSLOTS; s++) begin
                r_slot_lo[s]   <= 64'd0;
                r_slot_rate[s] <= 32'd0;
                r_head[s]      <= '0;
                r_fill[s]      <= '0;
            end
            for (int s = 0; s < FLOWS_PER_FAMILY; s++) begin
                r_slot_hi[s] <= 64'd0;
            end
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_slot <= '0;
                end
                S_DEC: begin
                    r_out_valid <= 1'b1;
                    if (r_item.kind == K_OTHER) begin
                        r_verdict  <= VERDICT_PASS;
                        r_cls      <= 2'd0;
                        r_out_rate <= 32'd0;
                    end else begin
                        r_verdict  <= w_drop ? VERDICT_DROP : VERDICT_PASS;
                        r_cls      <= w_cls;
                        r_out_rate <= r_rate;
                        if (!w_drop && r_claim) begin
                            r_slot_lo[r_cslot] <= r_item.lo;
                            if (w_v6) begin
                                r_slot_hi[FSW'(r_cslot - SW'(FLOWS_PER_FAMILY))] <= r_item.hi;
                            end
                            r_head[r_cslot] <= (r_head[r_cslot] == RIW'(RING_DEPTH - 1)) ?
                                               '0 : r_head[r_cslot] + 1'b1;
                            if (r_fill[r_cslot] != FW'(RING_DEPTH)) begin
                                r_fill[r_cslot] <= r_fill[r_cslot] + 1'b1;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (r_dcnt == 5'd31) begin
                        r_slot_rate[r_slot] <= {r_dq[30:0], w_dbit};
                        r_slot <= r_slot + 1'b1;
                    end
                end
                S_T_OUT: begin
                    r_out_valid <= 1'b1;
                    r_verdict   <= VERDICT_TICK;
                    r_cls       <= 2'd0;
                    r_out_rate  <= 32'd0;
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_verdict     = r_verdict;
    assign o_class_index = r_cls;
    assign o_flow_rate   = r_out_rate;

endmodule

/* sv/usage_dependent_drop_policer.sv */
// ----------------------------------------------------------------------------
// usage_dependent_drop_policer
// Per-destination usage policer with ring-logged byte rates.
// ----------------------------------------------------------------------------
// A packet passes through the back end as dequeue, slot lookup, then decision
// with ring write; other-family packets take the same steps without the ring
// write. A tick walks every slot's ring one entry at a time (registered memory
// read, then check) and divides each sum with a bit-serial divider. A two-entry
// queue takes input while the back end works; results sit in an output register.
module usage_dependent_drop_policer import uddp_pkg::*; #(
    parameter int FLOWS_PER_FAMILY = 5,
    parameter int RING_DEPTH       = 1024,
    parameter int NUM_CLASSES      = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [1:0]  i_family,
    input  logic [63:0] i_addr_low,
    input  logic [63:0] i_addr_high,
    input  logic [15:0] i_frame_length,
    input  logic [63:0] i_time_ns,
    input  logic [31:0] i_random_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_verdict,
    output logic [1:0]  o_class_index,
    output logic [31:0] o_flow_rate,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg   r_cfg;
    logic   w_q_valid, w_q_pop;
    t_item  w_q_item;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval <= 12'd60;
            r_cfg.limit[0] <= 32'd250000;
            r_cfg.limit[1] <= 32'd3750000;
            r_cfg.limit[2] <= 32'd125000000;
            r_cfg.level[0] <= 32'd0;
            r_cfg.level[1] <= 32'd2147484;
            r_cfg.level[2] <= 32'd4294967;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_INTERVAL: r_cfg.interval <= pwdata[11:0];
                REG_LIMIT_0:  r_cfg.limit[0] <= pwdata;
                REG_LIMIT_1:  r_cfg.limit[1] <= pwdata;
                REG_LIMIT_2:  r_cfg.limit[2] <= pwdata;
                REG_LEVEL_0:  r_cfg.level[0] <= pwdata;
                REG_LEVEL_1:  r_cfg.level[1] <= pwdata;
                REG_LEVEL_2:  r_cfg.level[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_INTERVAL: prdata = {20'd0, r_cfg.interval};
            REG_LIMIT_0:  prdata = r_cfg.limit[0];
            REG_LIMIT_1:  prdata = r_cfg.limit[1];
            REG_LIMIT_2:  prdata = r_cfg.limit[2];
            REG_LEVEL_0:  prdata = r_cfg.level[0];
            REG_LEVEL_1:  prdata = r_cfg.level[1];
            REG_LEVEL_2:  prdata = r_cfg.level[2];
            default:      prdata = 32'd0;
        endcase
    end

    uddp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_family       (i_family),
        .i_addr_low     (i_addr_low),
        .i_addr_high    (i_addr_high),
        .i_frame_length (i_frame_length),
        .i_time_ns      (i_time_ns),
        .i_random_word  (i_random_word),
        .o_q_valid      (w_q_valid),
        .o_q_item       (w_q_item),
        .i_q_pop        (w_q_pop)
    );

    uddp_back #(
        .FLOWS_PER_FAMILY (FLOWS_PER_FAMILY),
        .RING_DEPTH       (RING_DEPTH),
        .NUM_CLASSES      (NUM_CLASSES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_verdict     (o_verdict),
        .o_class_index (o_class_index),
        .o_flow_rate   (o_flow_rate)
    );

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the usage policer against a behavioral copy of its slot and ring
// logic: directed table first, then random phases under several settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import uddp_pkg::*;

    localparam int FLOWS = 5;
    localparam int NSLOT = 2 * FLOWS;
    localparam int DEPTH = 1024;
    localparam int PHASE_ITEMS = 90;

    typedef struct {
        bit          tick;
        logic [1:0]  fam;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [15:0] len;
        logic [63:0] tm;
        logic [31:0] rnd;
        bit          typed;
        logic [1:0]  verdict;
        logic [1:0]  cls;
        logic [31:0] rate;
    } t_req;

    typedef struct {
        logic [1:0]  verdict;
        logic [1:0]  cls;
        logic [31:0] rate;
    } t_res;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready, i_ready, o_valid;
    logic        i_req_type;
    logic [1:0]  i_family;
    logic [63:0] i_addr_low, i_addr_high, i_time_ns;
    logic [15:0] i_frame_length;
    logic [31:0] i_random_word;
    logic [1:0]  o_verdict, o_class_index;
    logic [31:0] o_flow_rate;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;

    usage_dependent_drop_policer dut (.*);

    // policer model state
    logic [11:0] m_interval;
    logic [31:0] m_limit[3];
    logic [31:0] m_level[3];
    logic [63:0] flow_lo[NSLOT];
    logic [63:0] flow_hi[FLOWS];
    logic [31:0] flow_bps[NSLOT];
    logic [16:0] log_len[NSLOT*DEPTH];
    logic [63:0] log_time[NSLOT*DEPTH];
    bit          log_ok[NSLOT*DEPTH];
    int          log_head[NSLOT];

    t_req   sent_q[$];
    t_res   verdict_q[$];
    int     err_cnt = 0;
    bit     idle_en = 1;
    logic [63:0] v4_pool[7];
    logic [63:0] v6_lo_pool[7];
    logic [63:0] v6_hi_pool[7];
    logic [63:0] clock_ns;

    function automatic logic [31:0] window_rate(int s, logic [63:0] now);
        logic [31:0] div;
        logic [63:0] win;
        logic [31:0] sum;
        int idx, a;
        div = (m_interval == 0) ? 32'd1 : 32'(m_interval);
        win = 64'(div) * 64'd1000000000;
        sum = 0;
        idx = (log_head[s] == 0) ? DEPTH - 1 : log_head[s] - 1;
        for (int k = 0; k < DEPTH; k++) begin
            a = s * DEPTH + idx;
            if (!log_ok[a]) break;
            if (log_time[a] > now || now - log_time[a] > win) break;
            if (sum > 32'hFFFF_FFFF - 32'(log_len[a])) sum = 32'hFFFF_FFFF;
            else sum = sum + 32'(log_len[a]);
            idx = (idx == 0) ? DEPTH - 1 : idx - 1;
        end
        return sum / div;
    endfunction

    function automatic t_res police(t_req q);
        t_res r;
        bit v6, hit;
        logic [63:0] lo, hi;
        int base, a, cls;
        r = '{VERDICT_PASS, 2'd0, 32'd0};
        if (q.tick) begin
            for (int s = 0; s < NSLOT; s++) flow_bps[s] = window_rate(s, q.tm);
            r.verdict = VERDICT_TICK;
            return r;
        end
        if (q.fam > 1) return r;
        v6 = (q.fam == 1);
        lo = v6 ? q.lo : {32'd0, q.lo[31:0]};
        hi = v6 ? q.hi : 64'd0;
        base = v6 ? FLOWS : 0;
        for (int s = base; s < base + FLOWS; s++) begin
            if (flow_lo[s] == lo && (!v6 || flow_hi[s-FLOWS] == hi)) begin
                r.rate = flow_bps[s];
                break;
            end
        end
        cls = 2;
        for (int c = 0; c < 3; c++) begin
            if (r.rate < m_limit[c]) begin
                cls = c;
                break;
            end
        end
        r.cls = 2'(cls);
        if (m_level[cls] != 0 && m_level[cls] >= q.rnd) begin
            r.verdict = VERDICT_DROP;
            return r;
        end
        for (int s = base; s < base + FLOWS; s++) begin
            hit = flow_lo[s] == lo && (!v6 || flow_hi[s-FLOWS] == hi);
            if (!hit && flow_lo[s] == 0 && (!v6 || flow_hi[s-FLOWS] == 0)) begin
                flow_lo[s] = lo;
                if (v6) flow_hi[s-FLOWS] = hi;
                hit = 1;
            end
            if (hit) begin
                a = s * DEPTH + log_head[s];
                log_len[a] = 17'(q.len) + 17'(ETH_HDR);
                log_time[a] = q.tm;
                log_ok[a] = 1;
                log_head[s] = (log_head[s] + 1 >= DEPTH) ? 0 : log_head[s] + 1;
                break;
            end
        end
        return r;
    endfunction

    // transaction monitor and scoreboard
    always @(posedge i_clk) begin
        t_req q;
        t_res r, got;
        if (i_rst_n && i_valid && o_ready) begin
            q = sent_q.pop_front();
            r = police(q);
            if (q.typed) r = '{q.verdict, q.cls, q.rate};
            verdict_q.push_back(r);
        end
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_verdict, o_class_index, o_flow_rate};
            if (verdict_q.size() == 0) begin
                $error("result with nothing expected: verdict %0d", got.verdict);
                err_cnt++;
            end else begin
                r = verdict_q.pop_front();
                if (got.verdict !== r.verdict) begin
                    $error("verdict: expected %0d, actual %0d", r.verdict, got.verdict);
                    err_cnt++;
                end
                if (got.cls !== r.cls) begin
                    $error("class_index: expected %0d, actual %0d", r.cls, got.cls);
                    err_cnt++;
                end
                if (got.rate !== r.rate) begin
                    $error("flow_rate: expected %0d, actual %0d", r.rate, got.rate);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("testbench: done, errors");
        $finish;
    end

    // receiver stalls
    initial begin
        i_ready <= 0;
        @(posedge i_clk);
        forever begin
            if (idle_en && $urandom_range(0, 4) == 0) begin
                i_ready <= 0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            i_ready <= 1;
            @(posedge i_clk);
        end
    end

    task automatic send(t_req q);
        sent_q.push_back(q);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid        <= 1;
        i_req_type     <= q.tick;
        i_family       <= q.fam;
        i_addr_low     <= q.lo;
        i_addr_high    <= q.hi;
        i_frame_length <= q.len;
        i_time_ns      <= q.tm;
        i_random_word  <= q.rnd;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1;
        pwrite  <= 1;
        penable <= 0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        @(posedge i_clk);
        case (idx)
            REG_INTERVAL: m_interval = val[11:0];
            REG_LIMIT_0:  m_limit[0] = val;
            REG_LIMIT_1:  m_limit[1] = val;
            REG_LIMIT_2:  m_limit[2] = val;
            REG_LEVEL_0:  m_level[0] = val;
            REG_LEVEL_1:  m_level[1] = val;
            REG_LEVEL_2:  m_level[2] = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        i_valid <= 0;
        while (verdict_q.size() != 0 || sent_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_req row(bit tick, logic [1:0] fam, logic [63:0] lo,
                                 logic [63:0] hi, logic [15:0] len, logic [63:0] tm,
                                 logic [31:0] rnd, bit typed = 0,
                                 logic [1:0] v = VERDICT_PASS, logic [1:0] c = 0,
                                 logic [31:0] rt = 0);
        return '{tick, fam, lo, hi, len, tm, rnd, typed, v, c, rt};
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_req random_req();
        t_req q;
        int p;
        q = row(0, 2'd0, rnd64(), rnd64(), 16'($urandom), 64'd0, $urandom);
        clock_ns = clock_ns + 64'($urandom_range(0, 300000000));
        q.tm = ($urandom_range(0, 32) == 0) ? rnd64() : clock_ns;
        if ($urandom_range(0, 1) == 0) q.rnd = $urandom_range(0, 8000000);
        if ($urandom_range(0, 2) == 0) q.len = $urandom_range(0, 1500);
        p = $urandom_range(0, 99);
        if (p < 5) begin
            q.tick = 1;
            q.fam = 2'($urandom);
        end else if (p < 12) begin
            q.fam = 2'($urandom_range(2, 3));
        end else if ($urandom_range(0, 9) != 0) begin
            p = $urandom_range(0, 6);
            q.fam = 2'($urandom_range(0, 1));
            if (q.fam == 0) q.lo = {q.lo[63:32], v4_pool[p][31:0]};
            else begin
                q.lo = v6_lo_pool[p];
                q.hi = v6_hi_pool[p];
            end
        end else begin
            q.fam = 2'($urandom_range(0, 1));
        end
        return q;
    endfunction

    initial begin
        t_req table_rows[$];
        logic [31:0] phase_cfg[5][7];

        phase_cfg = '{
            '{32'd1,    32'd50000,      32'd200000,     32'd1000000,
              32'd0,    32'h4000_0000,  32'hFFFF_FFFF},
            '{32'd4095, 32'd0,          32'd0,          32'd0,
              32'd0,    32'd0,          32'd0},
            '{32'd0,    32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'd0,     32'd0},
            '{32'd3600, 32'd100,        32'd20000,      32'd300000,
              32'd2147484, 32'd4294967, 32'h8000_0000},
            '{32'd2,    32'd60000,      32'd120000,     32'd400000,
              32'd8000000, 32'd0,       32'd12345678}
        };

        i_rst_n <= 0;
        i_valid <= 0;
        i_req_type <= 0;
        i_family <= 0;
        i_addr_low <= 0;
        i_addr_high <= 0;
        i_frame_length <= 0;
        i_time_ns <= 0;
        i_random_word <= 0;
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        paddr <= 0;
        pwdata <= 0;

        m_interval = 12'd60;
        m_limit = '{32'd250000, 32'd3750000, 32'd125000000};
        m_level = '{32'd0, 32'd2147484, 32'd4294967};
        for (int s = 0; s < NSLOT; s++) begin
            flow_lo[s] = 0;
            flow_bps[s] = 0;
            log_head[s] = 0;
        end
        for (int s = 0; s < FLOWS; s++) flow_hi[s] = 0;
        for (int a = 0; a < NSLOT * DEPTH; a++) log_ok[a] = 0;
        v4_pool[0] = 0;
        v6_lo_pool[0] = 0;
        v6_hi_pool[0] = 0;
        for (int p = 1; p < 7; p++) begin
            v4_pool[p] = {32'd0, $urandom};
            v6_lo_pool[p] = rnd64();
            v6_hi_pool[p] = (p == 1) ? 64'd0 : rnd64();
        end
        clock_ns = 64'd1000000000;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed table
        table_rows.push_back(row(0, 2'd2, '1, '1, '1, '1, 0, 1));
        table_rows.push_back(row(0, 2'd3, '1, '1, '1, '1, '1, 1));
        table_rows.push_back(row(1, 2'd0, 0, 0, 0, 0, 0, 1, VERDICT_TICK));
        table_rows.push_back(row(0, 2'd0, 0, 0, 0, 1000, 0, 1));  // zero address
        table_rows.push_back(row(0, 2'd0, 64'hFFFF_FFFF_C0A8_0001, '1, '1, 2000, '1, 1));
        table_rows.push_back(row(0, 2'd0, 64'hC0A8_0001, 0, 1500, 3000, 0));
        table_rows.push_back(row(0, 2'd0, 64'h2, 0, 60, 3100, 0));
        table_rows.push_back(row(0, 2'd0, 64'h3, 0, 60, 3200, 0));
        table_rows.push_back(row(0, 2'd0, 64'h4, 0, 60, 3300, 0));
        table_rows.push_back(row(0, 2'd0, 64'h5, 0, 60, 3400, '1));  // last free slot
        table_rows.push_back(row(0, 2'd1, '1, '1, 100, 4000, '1));
        table_rows.push_back(row(0, 2'd1, 0, 0, 200, 4100, '1));
        table_rows.push_back(row(0, 2'd1, 0, 1, 300, 4200, '1));
        table_rows.push_back(row(1, 2'd1, 0, 0, 0, 500000000, 0, 1, VERDICT_TICK));
        table_rows.push_back(row(0, 2'd0, 64'hC0A8_0001, 0, 10, 600000000, 0));
        table_rows.push_back(row(0, 2'd0, 64'h5, 0, 10, 600000001, 0));
        table_rows.push_back(row(0, 2'd1, '1, '1, 10, 700000000, 0));
        table_rows.push_back(row(1, 2'd0, 0, 0, 0, '1, 0, 1, VERDICT_TICK));
        table_rows.push_back(row(0, 2'd0, 64'hC0A8_0001, 0, 10, 800000000, 0));
        table_rows.push_back(row(1, 2'd0, 0, 0, 0, 0, 0, 1, VERDICT_TICK));
        table_rows.push_back(row(0, 2'd1, '1, '1, 10, 900000000, 0));
        foreach (table_rows[n]) send(table_rows[n]);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            for (int i = 0; i < 7; i++) reg_write(3'(i), phase_cfg[ph][i]);
            if (ph == 4) idle_en = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) send(random_req());
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (err_cnt == 0 && verdict_q.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
